>>> sv/wsd_pkg.sv
package wsd_pkg;

  // Width of the payload byte counter; frames longer than it can count are rejected.
  localparam int COUNT_BITS = 32;

  localparam logic [63:0] COUNT_MAX = (COUNT_BITS >= 64) ? {64{1'b1}}
                                    : ((64'd1 << COUNT_BITS) - 64'd1);

  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd10485760;

  // Header field codes.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] MASK_BYTES = 4'd4;

  localparam logic [3:0] OP_CONT = 4'h0;
  localparam logic [3:0] OP_TEXT = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_PING = 4'h9;
  localparam logic [3:0] OP_PONG = 4'hA;

  typedef enum logic [4:0] {
    PH_HDR0 = 5'b00001,
    PH_HDR1 = 5'b00010,
    PH_EXT  = 5'b00100,
    PH_MASK = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  // Contents of the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } wsd_item_t;

  // One result headed for the output register.
  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic [3:0] opcode;
    logic       frame_last;
    logic       message_last;
    logic       close_request;
  } wsd_res_t;

endpackage

>>> sv/wsd_if.sv
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [3:0] opcode;
  logic       frame_last;
  logic       message_last;
  logic       close_request;

  modport source (output valid, output out_byte, output opcode, output frame_last,
                  output message_last, output close_request, input ready);
  modport sink (input valid, input out_byte, input opcode, input frame_last,
                input message_last, input close_request, output ready);
endinterface

>>> sv/wsd_in_stage.sv
module wsd_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  output logic               in_ready,
  input  logic               take,
  output wsd_pkg::wsd_item_t item
);
  import wsd_pkg::*;

  logic       valid_r;
  logic [7:0] data_r;

  assign in_ready = !valid_r || take;
  assign item.valid = valid_r;
  assign item.data = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_byte;
    end
  end

endmodule

>>> sv/wsd_parser.sv
module wsd_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data,
  input  wsd_pkg::wsd_item_t item,
  input  logic               out_free,
  output logic               take,
  output wsd_pkg::wsd_res_t  res
);
  import wsd_pkg::*;

  phase_t                  phase_r, phase_nxt;
  logic [3:0]              hdr_cnt_r, hdr_cnt_nxt;
  logic [3:0]              ext_bytes_r, ext_bytes_nxt;
  logic [63:0]             len_r, len_nxt;
  logic [COUNT_BITS-1:0]   pay_cnt_r, pay_cnt_nxt;
  logic [31:0]             mask_key_r, mask_key_nxt;
  logic                    mask_on_r, mask_on_nxt;
  logic                    fin_r, fin_nxt;
  logic                    err_r, err_nxt;
  logic [3:0]              op_r, op_nxt;
  logic [31:0]             max_pay_r;

  logic [7:0]              b;
  logic [3:0]              hdr_inc;
  logic [COUNT_BITS-1:0]   pay_inc;
  logic [7:0]              key_byte;
  logic                    hdr_done;
  logic [63:0]             chk_len;
  logic                    reject;
  logic                    last;
  logic                    emit;
  wsd_res_t                calc;

  assign b = item.data;
  assign hdr_inc = hdr_cnt_r + 4'd1;
  assign pay_inc = pay_cnt_r + 1'b1;

  always_comb begin
    case (pay_cnt_r[1:0])
      2'd0:    key_byte = mask_key_r[31:24];
      2'd1:    key_byte = mask_key_r[23:16];
      2'd2:    key_byte = mask_key_r[15:8];
      default: key_byte = mask_key_r[7:0];
    endcase
    if (!mask_on_r) begin
      key_byte = 8'd0;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    ext_bytes_nxt = ext_bytes_r;
    len_nxt      = len_r;
    pay_cnt_nxt  = pay_cnt_r;
    mask_key_nxt = mask_key_r;
    mask_on_nxt  = mask_on_r;
    fin_nxt      = fin_r;
    err_nxt      = err_r;
    op_nxt       = op_r;
    hdr_done     = 1'b0;
    chk_len      = len_r;
    reject       = 1'b0;
    last         = 1'b0;
    emit         = 1'b0;
    calc         = '0;
    calc.opcode  = op_r;

    case (phase_r)
      PH_HDR1: begin
        mask_on_nxt  = b[7];
        mask_key_nxt = '0;
        hdr_cnt_nxt  = '0;
        if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
          ext_bytes_nxt = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          len_nxt = '0;
          phase_nxt = PH_EXT;
        end else begin
          ext_bytes_nxt = '0;
          len_nxt = {57'd0, b[6:0]};
          if (b[7]) begin
            phase_nxt = PH_MASK;
          end else begin
            hdr_done = 1'b1;
            chk_len = len_nxt;
          end
        end
      end
      PH_EXT: begin
        len_nxt = {len_r[55:0], b};
        hdr_cnt_nxt = hdr_inc;
        if (hdr_inc >= ext_bytes_r) begin
          hdr_cnt_nxt = '0;
          if (mask_on_r) begin
            phase_nxt = PH_MASK;
          end else begin
            hdr_done = 1'b1;
            chk_len = len_nxt;
          end
        end
      end
      PH_MASK: begin
        mask_key_nxt = {mask_key_r[23:0], b};
        hdr_cnt_nxt = hdr_inc;
        if (hdr_inc >= MASK_BYTES) begin
          hdr_done = 1'b1;
        end
      end
      PH_DATA: begin
        pay_cnt_nxt = pay_inc;
        last = (64'(pay_inc) == len_r);
        emit = 1'b1;
        calc.out_byte = b ^ key_byte;
        calc.frame_last = last;
        calc.message_last = last && fin_r;
        if (last) begin
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
        fin_nxt = b[7];
        op_nxt = b[3:0];
        err_nxt = (b[6:4] != 3'd0) ||
                  !(b[3:0] == OP_CONT || b[3:0] == OP_TEXT || b[3:0] == OP_BINARY ||
                    b[3:0] == OP_PING || b[3:0] == OP_PONG);
        phase_nxt = PH_HDR1;
      end
    endcase

    // Header complete: either the frame is rejected with a close result or data begins.
    if (hdr_done) begin
      reject = err_r || (chk_len == 64'd0) || (chk_len > {32'd0, max_pay_r}) ||
               (chk_len > COUNT_MAX);
      if (reject) begin
        err_nxt = 1'b1;
        emit = 1'b1;
        calc.close_request = 1'b1;
        phase_nxt = PH_HDR0;
      end else begin
        pay_cnt_nxt = '0;
        phase_nxt = PH_DATA;
      end
    end
  end

  // A byte that yields nothing moves on even while the output register is full.
  assign take = item.valid && (out_free || !emit);

  always_comb begin
    res = calc;
    res.valid = take && emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pay_r <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_pay_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      hdr_cnt_r   <= '0;
      ext_bytes_r <= '0;
      len_r       <= '0;
      pay_cnt_r   <= '0;
      mask_key_r  <= '0;
      mask_on_r   <= 1'b0;
      fin_r       <= 1'b0;
      err_r       <= 1'b0;
      op_r        <= '0;
    end else if (take) begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      ext_bytes_r <= ext_bytes_nxt;
      len_r       <= len_nxt;
      pay_cnt_r   <= pay_cnt_nxt;
      mask_key_r  <= mask_key_nxt;
      mask_on_r   <= mask_on_nxt;
      fin_r       <= fin_nxt;
      err_r       <= err_nxt;
      op_r        <= op_nxt;
    end
  end

endmodule

>>> sv/wsd_out_stage.sv
module wsd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  wsd_pkg::wsd_res_t res,
  output logic              out_free,
  wsd_out_if.source         out_ch
);
  import wsd_pkg::*;

  logic     valid_r;
  wsd_res_t data_r;

  assign out_free = !valid_r || out_ch.ready;

  assign out_ch.valid         = valid_r;
  assign out_ch.out_byte      = data_r.out_byte;
  assign out_ch.opcode        = data_r.opcode;
  assign out_ch.frame_last    = data_r.frame_last;
  assign out_ch.message_last  = data_r.message_last;
  assign out_ch.close_request = data_r.close_request;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res.valid) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      data_r <= res;
    end
  end

endmodule

>>> sv/websocket_frame_decoder.sv
// WebSocket receive-side frame decoder.
// in_ch carries the raw stream, one byte per item. Header bytes (two base bytes,
// an optional 2- or 8-byte extended length, an optional 4-byte mask key) produce no
// item on out_ch, except that a rejected header gives one close item on its last byte.
// Each payload byte gives one item: the unmasked byte, the frame opcode, and flags
// for the last byte of the frame and of the message.
// cfg_we/cfg_data write the largest accepted frame length; write it only while idle.
// The input accept loads the input register; the item then passes through the parse
// logic into the output register, which drives out_ch.valid. One byte is taken every
// cycle unless a byte that yields a result waits on the full output register; the
// parser state loop updates once per byte.
// When out_ch stalls, the output register holds its item; header bytes still move
// through, and the input register keeps taking bytes until a byte that yields a
// result is waiting on the full output register.
// Reset (rst_n low, synchronous) empties both registers, returns the parser to the
// first header byte and restores the length limit to 10 MiB.
module websocket_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  wsd_in_if.sink      in_ch,
  wsd_out_if.source   out_ch
);
  import wsd_pkg::*;

  wsd_item_t item;
  wsd_res_t  res;
  logic      take;
  logic      out_free;

  wsd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.in_byte),
    .in_ready (in_ch.ready),
    .take     (take),
    .item     (item)
  );

  wsd_parser u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (item),
    .out_free (out_free),
    .take     (take),
    .res      (res)
  );

  wsd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

  a_res_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> item.valid && out_free)
    else $error("result produced without a held input byte or free output");

  a_close_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.close_request |->
      out_ch.out_byte == 8'd0 && !out_ch.frame_last && !out_ch.message_last)
    else $error("close item carries payload or last flags");

  a_msg_implies_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.message_last |-> out_ch.frame_last)
    else $error("message end without frame end");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> item.valid)
    else $error("accepted byte not held in input register");

endmodule

>>> tb/testbench.sv
module testbench;
  import wsd_pkg::*;

  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] opcode;
    logic       frame_last;
    logic       message_last;
    logic       close_request;
  } frame_res_t;

  typedef enum logic [1:0] {ROW_SILENT, ROW_PREDICTED, ROW_TYPED} row_kind_t;

  typedef struct packed {
    logic [7:0] b;
    row_kind_t  kind;
    frame_res_t res;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_data;

  wsd_in_if  in_ch ();
  wsd_out_if out_ch ();

  websocket_frame_decoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  // Parser state of the predictor.
  phase_t                ws_phase;
  logic [3:0]            ws_hdr_cnt;
  logic [3:0]            ws_ext_bytes;
  logic [63:0]           ws_len;
  logic [COUNT_BITS-1:0] ws_count;
  logic [31:0]           ws_key;
  logic                  ws_masked;
  logic                  ws_fin;
  logic                  ws_bad;
  logic [3:0]            ws_op;
  logic [31:0]           ws_limit;

  frame_res_t decoded_q[$];
  int         errors;
  int         sent_bytes;
  int         cycles;
  int         stall_left;
  bit         quiet;

  // Bytes 1-8: masked pong of two bytes with a 16-bit length. Then a text frame
  // without fin, a 64-bit length just over the default limit, a header with all
  // reserved bits and an unknown opcode, a zero-length ping and a close frame.
  dir_row_t dir_rows [29] = '{
    '{8'h8A, ROW_SILENT, '0}, '{8'hFE, ROW_SILENT, '0}, '{8'h00, ROW_SILENT, '0},
    '{8'h02, ROW_SILENT, '0}, '{8'hFF, ROW_SILENT, '0}, '{8'h00, ROW_SILENT, '0},
    '{8'hA5, ROW_SILENT, '0}, '{8'h5A, ROW_SILENT, '0},
    '{8'h00, ROW_PREDICTED, '0}, '{8'hFF, ROW_PREDICTED, '0},
    '{8'h01, ROW_SILENT, '0}, '{8'h01, ROW_SILENT, '0}, '{8'h7E, ROW_PREDICTED, '0},
    '{8'h80, ROW_SILENT, '0}, '{8'h7F, ROW_SILENT, '0}, '{8'h00, ROW_SILENT, '0},
    '{8'h00, ROW_SILENT, '0}, '{8'h00, ROW_SILENT, '0}, '{8'h00, ROW_SILENT, '0},
    '{8'h00, ROW_SILENT, '0}, '{8'hA0, ROW_SILENT, '0}, '{8'h00, ROW_SILENT, '0},
    '{8'h01, ROW_TYPED, '{8'h00, OP_CONT, 1'b0, 1'b0, 1'b1}},
    '{8'hFF, ROW_SILENT, '0},
    '{8'h00, ROW_TYPED, '{8'h00, 4'hF, 1'b0, 1'b0, 1'b1}},
    '{8'h09, ROW_SILENT, '0},
    '{8'h00, ROW_TYPED, '{8'h00, OP_PING, 1'b0, 1'b0, 1'b1}},
    '{8'h88, ROW_SILENT, '0},
    '{8'h01, ROW_TYPED, '{8'h00, OP_CLOSE, 1'b0, 1'b0, 1'b1}}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int pick_pause();
    int r;
    if (quiet)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Header complete: either reject the frame with a close item or enter the payload.
  function automatic bit close_or_start(output frame_res_t r);
    r = '0;
    if (ws_bad || ws_len == 64'd0 || ws_len > 64'(ws_limit) || ws_len > COUNT_MAX) begin
      ws_bad = 1'b1;
      r.opcode = ws_op;
      r.close_request = 1'b1;
      ws_phase = PH_HDR0;
      return 1'b1;
    end
    ws_count = '0;
    ws_phase = PH_DATA;
    return 1'b0;
  endfunction

  function automatic bit length_done(output frame_res_t r);
    r = '0;
    ws_hdr_cnt = '0;
    if (ws_masked) begin
      ws_phase = PH_MASK;
      return 1'b0;
    end
    return close_or_start(r);
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, output frame_res_t r);
    logic [7:0] k;
    logic       done;
    r = '0;
    case (ws_phase)
      PH_HDR1: begin
        ws_masked = b[7];
        ws_key = '0;
        ws_hdr_cnt = '0;
        if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
          ws_ext_bytes = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          ws_len = '0;
          ws_phase = PH_EXT;
          return 1'b0;
        end
        ws_ext_bytes = '0;
        ws_len = {57'd0, b[6:0]};
        return length_done(r);
      end
      PH_EXT: begin
        ws_len = {ws_len[55:0], b};
        ws_hdr_cnt = ws_hdr_cnt + 4'd1;
        if (ws_hdr_cnt >= ws_ext_bytes)
          return length_done(r);
        return 1'b0;
      end
      PH_MASK: begin
        ws_key = {ws_key[23:0], b};
        ws_hdr_cnt = ws_hdr_cnt + 4'd1;
        if (ws_hdr_cnt >= MASK_BYTES)
          return close_or_start(r);
        return 1'b0;
      end
      PH_DATA: begin
        // The key index follows the byte position within the current frame.
        k = ws_masked ? 8'(ws_key >> (24 - 8 * int'(ws_count[1:0]))) : 8'd0;
        ws_count = ws_count + 1'b1;
        done = (64'(ws_count) == ws_len);
        r.data = b ^ k;
        r.opcode = ws_op;
        r.frame_last = done;
        r.message_last = done & ws_fin;
        if (done)
          ws_phase = PH_HDR0;
        return 1'b1;
      end
      default: begin
        ws_fin = b[7];
        ws_op = b[3:0];
        ws_bad = (b[6:4] != 3'd0) ||
                 !(b[3:0] inside {OP_CONT, OP_TEXT, OP_BINARY, OP_PING, OP_PONG});
        ws_phase = PH_HDR1;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b, input row_kind_t kind,
                           input frame_res_t typed);
    frame_res_t r;
    int         pause;
    bit         hit;
    pause = pick_pause();
    if (pause > 0) begin
      in_ch.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    hit = decode_byte(b, r);
    if (kind == ROW_TYPED)
      decoded_q = {decoded_q, typed};
    else if (kind == ROW_PREDICTED && hit)
      decoded_q = {decoded_q, r};
    sent_bytes++;
  endtask

  // Finish whatever frame the stream is in, so the next item starts a header.
  task automatic realign();
    while (ws_phase != PH_HDR0)
      push_byte((ws_phase == PH_DATA) ? 8'($urandom) : 8'h00, ROW_PREDICTED, '0);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic send_frame(input bit allow_noise);
    logic [7:0]  seq[$];
    logic [3:0]  op;
    logic [2:0]  rsv;
    logic [63:0] len;
    logic [31:0] key;
    logic        fin;
    logic        masked;
    logic        good;
    int          r;
    int          enc;
    int          n;
    if (allow_noise && $urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 4)) seq = {seq, 8'($urandom)};
    end else begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        case ($urandom_range(0, 4))
          0: op = OP_CONT;
          1: op = OP_TEXT;
          2: op = OP_BINARY;
          3: op = OP_PING;
          default: op = OP_PONG;
        endcase
      end else if (r < 92) begin
        op = OP_CLOSE;
      end else begin
        op = 4'($urandom);
      end
      rsv = ($urandom_range(0, 99) < 8) ? 3'($urandom_range(1, 7)) : 3'd0;
      fin = 1'($urandom);
      masked = 1'($urandom);
      r = $urandom_range(0, 99);
      if (r < 68) begin
        len = 64'($urandom_range(1, 12));
      end else if (r < 76) begin
        len = '0;
      end else if (r < 86 && ws_limit <= 400) begin
        len = 64'(ws_limit) + 64'($urandom_range(0, 2));
        if (len != 64'd0)
          len = len - 64'd1;
      end else if (r < 94) begin
        len = 64'($urandom_range(13, 140));
      end else begin
        len = {32'($urandom_range(32'hFFFF_FFFF, 1)), 32'($urandom)};
      end
      seq = {seq, {fin, rsv, op}};
      enc = $urandom_range(0, 9);
      if (len < 126 && enc < 8) begin
        seq = {seq, {masked, len[6:0]}};
      end else if (len < 65536 && enc < 9) begin
        seq = {seq, {masked, LEN_EXT16}};
        seq = {seq, len[15:8]};
        seq = {seq, len[7:0]};
      end else begin
        seq = {seq, {masked, LEN_EXT64}};
        for (int i = 7; i >= 0; i--)
          seq = {seq, 8'(len >> (8 * i))};
      end
      key = $urandom;
      if (masked)
        for (int i = 3; i >= 0; i--)
          seq = {seq, 8'(key >> (8 * i))};
      good = rsv == 3'd0 && (op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_PING, OP_PONG}) &&
             len != 0 && len <= 64'(ws_limit) && len <= COUNT_MAX;
      if (good)
        repeat (int'(len)) seq = {seq, 8'($urandom)};
    end
    n = seq.size();
    // Now and then a frame is cut short and the stream runs on misaligned.
    if (allow_noise && n > 1 && $urandom_range(0, 19) == 0)
      n = $urandom_range(1, n - 1);
    for (int i = 0; i < n; i++)
      push_byte(seq[i], ROW_PREDICTED, '0);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Result side: check every accepted item, then choose ready for the next cycle.
  initial begin : receiver
    frame_res_t want;
    int         pause;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (decoded_q.size() == 0) begin
          $error("out item with nothing expected: out_byte 0x%0h", out_ch.out_byte);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          check_field("out_byte", want.data, out_ch.out_byte);
          check_field("opcode", 8'(want.opcode), 8'(out_ch.opcode));
          check_field("frame_last", 8'(want.frame_last), 8'(out_ch.frame_last));
          check_field("message_last", 8'(want.message_last), 8'(out_ch.message_last));
          check_field("close_request", 8'(want.close_request), 8'(out_ch.close_request));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        pause = pick_pause();
        out_ch.ready <= (pause == 0);
        stall_left = (pause > 0) ? pause - 1 : 0;
      end
    end
  end

  initial begin : stimulus
    logic [31:0] lim;
    int          start;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= '0;
    quiet = 1'b0;
    ws_phase = PH_HDR0;
    ws_hdr_cnt = '0;
    ws_ext_bytes = '0;
    ws_len = '0;
    ws_count = '0;
    ws_key = '0;
    ws_masked = 1'b0;
    ws_fin = 1'b0;
    ws_bad = 1'b0;
    ws_op = '0;
    ws_limit = MAX_PAYLOAD_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      push_byte(dir_rows[i].b, dir_rows[i].kind, dir_rows[i].res);

    for (int p = 0; p < 7; p++) begin
      drain();
      case (p)
        0: lim = 32'd1;
        1: lim = 32'd300;
        2: lim = 32'd0;
        3: lim = 32'hFFFF_FFFF;
        4: lim = $urandom_range(2, 4096);
        5: lim = MAX_PAYLOAD_RST;
        default: lim = $urandom_range(32'hFFFF_FFFF, 4097);
      endcase
      cfg_we <= 1'b1;
      cfg_data <= lim;
      @(posedge clk);
      cfg_we <= 1'b0;
      ws_limit = lim;
      quiet = (p == 2 || p == 5);
      start = sent_bytes;
      while (sent_bytes - start < 64) begin
        if ($urandom_range(0, 39) == 0)
          drain();
        realign();
        // Broken streams only where any length they produce stays short.
        send_frame(ws_limit <= 4096);
      end
      realign();
    end

    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

>>> websocket_frame_decoder.f
sv/wsd_pkg.sv
sv/wsd_if.sv
sv/wsd_in_stage.sv
sv/wsd_parser.sv
sv/wsd_out_stage.sv
sv/websocket_frame_decoder.sv
tb/testbench.sv
